// File: rtl/aes_block_cipher_defines.svh
// Assertion macros used by the checker file.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aes_pkg.sv
//------------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and round functions of the AES block cipher.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

    localparam int KEY_WORDS   = 4;
    localparam int ROUNDS      = KEY_WORDS + 6;
    localparam int SCHED_WORDS = 4 * (ROUNDS + 1);
    localparam int KW_AW       = $clog2(SCHED_WORDS);
    localparam int KEY_REG_NUM = 4;
    localparam int RND_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 2'd3;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // Key expansion command passed from the top level to the key unit.
    typedef struct packed {
        logic         start;
        logic [255:0] key;
    } key_cmd_t;

    // Round key write port from the key unit to the round key store.
    typedef struct packed {
        logic             busy;
        logic             wr_en;
        logic [KW_AW-1:0] wr_addr;
        logic [31:0]      wr_data;
    } key_wr_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = x;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, b);
            b = gmul(b, b);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = ginv(x);
        return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
        return ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
    endfunction

    // Constant substitution tables, built at elaboration.
    typedef logic [7:0] byte_tab_t [256];

    function automatic byte_tab_t make_sbox(input logic inv);
        byte_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        return t;
    endfunction

    localparam byte_tab_t SBOX     = make_sbox(1'b0);
    localparam byte_tab_t INV_SBOX = make_sbox(1'b1);

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte idx = r + 4 * c of the state (row r, column c); byte 0 is the top byte.
    function automatic logic [7:0] st_byte(input logic [127:0] s, input int idx);
        return s[127 - 8 * idx -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[st_byte(s, r + 4 * ((c + r) % 4))];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = st_byte(t, 4 * c);
                a1 = st_byte(t, 4 * c + 1);
                a2 = st_byte(t, 4 * c + 2);
                a3 = st_byte(t, 4 * c + 3);
                t[127 - 32 * c -: 32] = {
                    xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                    xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = st_byte(s, 4 * c);
            a1 = st_byte(s, 4 * c + 1);
            a2 = st_byte(s, 4 * c + 2);
            a3 = st_byte(s, 4 * c + 3);
            t[127 - 32 * c -: 32] = {
                gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
                gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
                gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
                gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = INV_SBOX[st_byte(s, r + 4 * c)];
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/aes_ram.sv
//------------------------------------------------------------------------------
// aes_ram
// Generic single-port-write, single-port-read RAM with a registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/aes_key_exp.sv
//------------------------------------------------------------------------------
// aes_key_exp
// Expands the cipher key into the round key store, one word per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aes_key_exp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire aes_pkg::key_cmd_t cmd,
    output aes_pkg::key_wr_t       wr
);

    localparam int NK = aes_pkg::KEY_WORDS;

    // The last NK words stay in a sliding window of registers.
    logic [31:0] win_reg [NK];
    logic [31:0] win_next [NK];
    logic [aes_pkg::KW_AW-1:0] idx_reg, idx_next;
    logic [$clog2(NK)-1:0]     phase_reg, phase_next;
    logic [7:0]                rcon_reg, rcon_next;
    logic                      busy_reg, busy_next;
    logic [31:0]               t;
    logic [31:0]               w_new;

    // Schedule word from the window.
    always_comb
    begin
        t = win_reg[NK - 1];
        if (phase_reg == '0)
        begin
            t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (NK > 6 && int'(phase_reg) == 4)
        begin
            t = aes_pkg::sub_word(t);
        end
        w_new = win_reg[0] ^ t;
    end

    // Sequencer: first the key words, then the derived words.
    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        rcon_next  = rcon_reg;
        win_next   = win_reg;
        wr.wr_en   = 1'b0;
        wr.wr_addr = idx_reg;
        wr.wr_data = w_new;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            phase_next = '0;
            rcon_next  = 8'h01;
            for (int i = 0; i < NK; i++)
            begin
                win_next[i] = cmd.key[255 - 32 * i -: 32];
            end
        end
        else if (busy_reg)
        begin
            wr.wr_en = 1'b1;
            if (int'(idx_reg) < NK)
            begin
                wr.wr_data = win_reg[idx_reg[$clog2(NK)-1:0]];
            end
            else
            begin
                for (int i = 0; i < NK - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[NK - 1] = w_new;
                phase_next = (int'(phase_reg) == NK - 1) ? '0 : phase_reg + 1'b1;
                if (phase_reg == '0)
                begin
                    rcon_next = aes_pkg::xtime(rcon_reg);
                end
            end
            if (int'(idx_reg) == aes_pkg::SCHED_WORDS - 1)
            begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 1'b1;
        end
        wr.busy = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            rcon_reg  <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

// File: rtl/aes_round_eng.sv
//------------------------------------------------------------------------------
// aes_round_eng
// Iterative round engine; fetches round keys from the store a round ahead.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aes_round_eng (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           action,
    input  wire logic [127:0]                   block,
    input  wire logic                           rk_valid,
    input  wire logic [127:0]                   rk_data,
    output logic      [aes_pkg::RND_W-1:0]      rk_round,
    output logic                                busy,
    output logic                                done,
    output logic      [127:0]                   result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_ROUND = 3'b100
    } eng_state_t;

    localparam logic [aes_pkg::RND_W-1:0] LAST = aes_pkg::RND_W'(aes_pkg::ROUNDS);

    eng_state_t                  state_reg, state_next;
    logic [aes_pkg::RND_W-1:0]   round_reg, round_next;
    logic                        dec_reg, dec_next;
    logic [127:0]                blk_reg, blk_next;
    logic                        done_next;
    logic [127:0]                enc_s, dec_s;

    // One round of either direction on the working block.
    always_comb
    begin
        enc_s = aes_pkg::enc_round(blk_reg, round_reg == LAST) ^ rk_data;
        dec_s = aes_pkg::inv_sub_shift(blk_reg) ^ rk_data;
        if (round_reg != LAST)
        begin
            dec_s = aes_pkg::inv_mix(dec_s);
        end
    end

    // Round counter sequencing; key address is the next round number, counted down when decrypting.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        dec_next   = dec_reg;
        blk_next   = blk_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FETCH;
                    round_next = '0;
                    dec_next   = action;
                    blk_next   = block;
                end
            end
            ST_FETCH:
            begin
                if (rk_valid)
                begin
                    blk_next   = blk_reg ^ rk_data;
                    round_next = round_reg + 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rk_valid)
                begin
                    blk_next = dec_reg ? dec_s : enc_s;
                    if (round_reg == LAST)
                    begin
                        round_next = '0;
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rk_round = dec_reg ? (LAST - round_next) : round_next;
    assign busy     = (state_reg != ST_IDLE);
    assign result   = blk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            dec_reg   <= 1'b0;
            blk_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            dec_reg   <= dec_next;
            blk_reg   <= blk_next;
            done      <= done_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/aes_block_cipher.sv
// From input transaction to result valid: a key fetch wait, the initial key addition, ten
// rounds, and the output register load; one round per cycle. The single round engine takes
// no new block until the previous result has left the output register. A key register
// write re-expands the schedule; reset clears control and keys.
//------------------------------------------------------------------------------
// aes_block_cipher
// Iterative AES-128 encrypt/decrypt core with a memory-held key schedule.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aes_block_cipher (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           action,
    input  wire logic [63:0]                    block_upper,
    input  wire logic [63:0]                    block_lower,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [63:0]                    result_upper,
    output logic      [63:0]                    result_lower
);

    localparam int RK_AW = $clog2(aes_pkg::ROUNDS + 1);

    logic [63:0]          key_reg [aes_pkg::KEY_REG_NUM];
    logic                 key_start_reg;
    aes_pkg::key_cmd_t    kcmd;
    aes_pkg::key_wr_t     kwr;
    logic                 cfg_fire, in_fire, out_fire;
    logic [aes_pkg::RND_W-1:0] rk_round;
    logic                 eng_busy, eng_done;
    logic [127:0]         eng_result;
    logic [127:0]         rk_data;
    logic                 out_valid_reg;
    logic [127:0]         out_reg;
    logic                 lane_sel_reg;

    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_ready = !kwr.busy && !eng_busy;
    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = eng_busy || eng_done || kwr.busy || key_start_reg || out_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    // Key registers; each write restarts the expansion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aes_pkg::KEY_REG_NUM; i++)
            begin
                key_reg[i] <= '0;
            end
            key_start_reg <= 1'b0;
        end
        else
        begin
            key_start_reg <= cfg_fire;
            if (cfg_fire)
            begin
                case (cfg_index)
                    aes_pkg::REG_KEY_0_7:   key_reg[0] <= cfg_data;
                    aes_pkg::REG_KEY_8_15:  key_reg[1] <= cfg_data;
                    aes_pkg::REG_KEY_16_23: key_reg[2] <= cfg_data;
                    aes_pkg::REG_KEY_24_31: key_reg[3] <= cfg_data;
                    default:                key_reg[0] <= key_reg[0];
                endcase
            end
        end
    end

    assign kcmd.start = key_start_reg;
    assign kcmd.key   = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    aes_key_exp u_key_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (kcmd),
        .wr    (kwr)
    );

    // Round key store: four lanes, one column word per lane, row per round.
    logic       lane_we [4];
    logic [RK_AW-1:0] rk_row;
    assign rk_row = rk_round[RK_AW-1:0];

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        assign lane_we[g] = kwr.wr_en && (kwr.wr_addr[1:0] == 2'(g));
        aes_ram #(
            .WIDTH (32),
            .DEPTH (aes_pkg::ROUNDS + 1)
        ) u_rk_ram (
            .clk     (clk),
            .wr_en   (lane_we[g]),
            .wr_addr (kwr.wr_addr[aes_pkg::KW_AW-1:2]),
            .wr_data (kwr.wr_data),
            .rd_addr (rk_row),
            .rd_data (rk_data[127 - 32 * g -: 32])
        );
    end

    // Key data lags its address by the registered RAM read, so the cycle after a start is a wait.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_sel_reg <= 1'b0;
        end
        else
        begin
            lane_sel_reg <= in_fire;
        end
    end

    aes_round_eng u_round_eng (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .action   (action),
        .block    ({block_upper, block_lower}),
        .rk_valid (!lane_sel_reg),
        .rk_data  (rk_data),
        .rk_round (rk_round),
        .busy     (eng_busy),
        .done     (eng_done),
        .result   (eng_result)
    );

    // Output register holds the result until the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_reg <= eng_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_upper = out_reg[127:64];
    assign result_lower = out_reg[63:0];

endmodule

`default_nettype wire

// File: rtl/aes_block_cipher_checker.sv
//------------------------------------------------------------------------------
// aes_block_cipher_checker
// Port-level checks of the cipher, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aes_block_cipher_defines.svh"

module aes_block_cipher_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] result_upper
);

    // A result waiting in the output register stays until taken.
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_upper), "result dropped while stalled")
    // An accepted block leaves the input side stalled next cycle.
    `AES_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall, "second block accepted during work")
    // No result appears right after a block is taken.
    `AES_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && !in_stall, !out_valid, "result too early")
    // A key write holds off blocks while the schedule is rebuilt.
    `AES_ASSERT_NEXT(a_cfg_hold, clk, rst_n, cfg_valid && cfg_ready, in_stall, "block taken during key load")

endmodule

bind aes_block_cipher aes_block_cipher_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_upper (result_upper)
);

`default_nettype wire
